>>> sv/cce_pkg.sv
// Shared types and constants of the cascaded comb echo block.
// No dependencies; the other files, cce_ram excepted, refer to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package cce_pkg;

    // Parameter defaults
    localparam int MAX_DELAY_DEF    = 4096;
    localparam int MAX_REPEAT_DEF   = 4;
    localparam int SAMPLE_WIDTH_DEF = 16;

    // Fixed field widths
    localparam int GAIN_W      = 17;
    localparam int DELAY_W     = 12;
    localparam int REPEAT_W    = 3;
    localparam int STAGE_GUARD = 8;   // stage values carry 8 bits of headroom
    localparam int FRAC_BITS   = 15;  // Q2.15 gain
    localparam int ROUND_HALF  = 16384;

    localparam logic signed [GAIN_W-1:0] GAIN_MAX = 17'sd32768;
    localparam logic signed [GAIN_W-1:0] GAIN_MIN = -17'sd32768;

    // Register reset values
    localparam logic [GAIN_W-1:0]   GAIN_RST   = 17'd16384;
    localparam logic [DELAY_W-1:0]  DELAY_RST  = 12'd1000;
    localparam logic [REPEAT_W-1:0] REPEAT_RST = 3'd1;

    // APB port
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // Register indexes (byte address / 4)
    localparam logic [1:0] REG_GAIN   = 2'd0;
    localparam logic [1:0] REG_DELAY  = 2'd1;
    localparam logic [1:0] REG_REPEAT = 2'd2;

    // Queue between front and back; depth must be a power of two
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // How a stage obtains its delayed tap
    typedef enum logic [1:0] {
        TAP_ZERO,   // tap reaches before clip start
        TAP_MEM,    // tap comes from the history ring
        TAP_SELF    // zero delay: tap is the stage input
    } t_tap;

endpackage

`default_nettype wire

>>> sv/cce_if.sv
// Stream interfaces for the sample input and the echoed result.
// Depends on cce_pkg for the default sample width.
`timescale 1ns / 1ps
`default_nettype none

interface cce_in_if #(
    parameter int SAMPLE_WIDTH = cce_pkg::SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_in;
    logic                           clip_start;

    modport source (output valid, output sample_in, output clip_start, input ready);
    modport sink   (input valid, input sample_in, input clip_start, output ready);
endinterface

interface cce_out_if #(
    parameter int SAMPLE_WIDTH = cce_pkg::SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_out;
    logic                           clipped;

    modport source (output valid, output sample_out, output clipped, input ready);
    modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

`default_nettype wire

>>> sv/cascaded_comb_echo_top.sv
// Top level of the cascaded comb echo block: APB registers, front end,
// queue and stage engine. Depends on cce_pkg, cce_if, cce_regs, cce_front, cce_back.
//
//   Port     | Dir | Handshake          | Carries
//   ---------+-----+--------------------+-------------------------------------
//   i_in     | in  | valid / ready      | sample_in, clip_start
//   o_out    | out | valid / ready      | sample_out, clipped
//   APB      | in  | psel/penable/pready| gain, delay, repeat count registers
//
// In the stage engine each transaction runs every comb stage on the shared
// multiplier (ST_MUL) and then on the adder/saturator (ST_ADD), all
// MAX_REPEAT stages always run so that their history rings stay current,
// and the history RAM read for a stage is issued in the state before its
// multiply. The front queue holds two transactions, so input is taken
// while the engine works or a result waits on o_out, until it is full.
// Reset (i_rst_n, synchronous, active low) clears pointers, counts, queue
// and result valid; the history RAM is not cleared and needs no pass.
`timescale 1ns / 1ps
`default_nettype none

module cascaded_comb_echo_top #(
    parameter int MAX_DELAY    = cce_pkg::MAX_DELAY_DEF,
    parameter int MAX_REPEAT   = cce_pkg::MAX_REPEAT_DEF,
    parameter int SAMPLE_WIDTH = cce_pkg::SAMPLE_WIDTH_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    cce_in_if.sink                          i_in,
    cce_out_if.source                       o_out,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [cce_pkg::APB_AW-1:0] paddr,
    input  wire logic [cce_pkg::APB_DW-1:0] pwdata,
    output logic      [cce_pkg::APB_DW-1:0] prdata,
    output logic                            pready
);

    localparam int PW = $clog2(MAX_DELAY);

    // Clamped configuration
    logic signed [cce_pkg::GAIN_W-1:0] gain;
    logic [PW-1:0]                     delay;
    logic [cce_pkg::REPEAT_W-1:0]      reps;

    // Front-to-back queue head
    logic                           q_valid;
    logic                           q_ready;
    logic signed [SAMPLE_WIDTH-1:0] q_sample;
    logic [PW-1:0]                  q_ptr;
    cce_pkg::t_tap                  q_mode;

    cce_regs #(
        .MAX_DELAY  (MAX_DELAY),
        .MAX_REPEAT (MAX_REPEAT)
    ) u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_gain  (gain),
        .o_delay (delay),
        .o_reps  (reps)
    );

    // Front: position tracking and tap classification at accept time
    cce_front #(
        .MAX_DELAY    (MAX_DELAY),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in.valid),
        .o_ready      (i_in.ready),
        .i_sample     (i_in.sample_in),
        .i_clip_start (i_in.clip_start),
        .i_delay      (delay),
        .o_q_valid    (q_valid),
        .i_q_ready    (q_ready),
        .o_q_sample   (q_sample),
        .o_q_ptr      (q_ptr),
        .o_q_mode     (q_mode)
    );

    // Back: stage engine, history RAM and result register
    cce_back #(
        .MAX_DELAY    (MAX_DELAY),
        .MAX_REPEAT   (MAX_REPEAT),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .o_q_ready  (q_ready),
        .i_q_sample (q_sample),
        .i_q_ptr    (q_ptr),
        .i_q_mode   (q_mode),
        .i_gain     (gain),
        .i_delay    (delay),
        .i_reps     (reps),
        .o_valid    (o_out.valid),
        .i_ready    (o_out.ready),
        .o_sample   (o_out.sample_out),
        .o_clipped  (o_out.clipped)
    );

endmodule

`default_nettype wire

>>> sv/cce_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module cce_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16384
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> sv/cce_regs.sv
// APB register file: gain, delay and repeat count, with range clamping.
// Depends on cce_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cce_regs #(
    parameter int MAX_DELAY  = cce_pkg::MAX_DELAY_DEF,
    parameter int MAX_REPEAT = cce_pkg::MAX_REPEAT_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [cce_pkg::APB_AW-1:0]         paddr,
    input  wire logic [cce_pkg::APB_DW-1:0]         pwdata,
    output logic      [cce_pkg::APB_DW-1:0]         prdata,
    output logic                                    pready,
    output logic signed [cce_pkg::GAIN_W-1:0]       o_gain,
    output logic      [$clog2(MAX_DELAY)-1:0]       o_delay,
    output logic      [cce_pkg::REPEAT_W-1:0]       o_reps
);

    localparam int PW = $clog2(MAX_DELAY);

    logic [cce_pkg::GAIN_W-1:0]   r_gain;
    logic [cce_pkg::DELAY_W-1:0]  r_delay;
    logic [cce_pkg::REPEAT_W-1:0] r_repeat;
    logic [1:0]                   reg_idx;
    logic                         wr_en;

    assign reg_idx = paddr[cce_pkg::APB_AW-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain   <= cce_pkg::GAIN_RST;
            r_delay  <= cce_pkg::DELAY_RST;
            r_repeat <= cce_pkg::REPEAT_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                cce_pkg::REG_GAIN:   r_gain   <= pwdata[cce_pkg::GAIN_W-1:0];
                cce_pkg::REG_DELAY:  r_delay  <= pwdata[cce_pkg::DELAY_W-1:0];
                cce_pkg::REG_REPEAT: r_repeat <= pwdata[cce_pkg::REPEAT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            cce_pkg::REG_GAIN:   prdata = cce_pkg::APB_DW'(r_gain);
            cce_pkg::REG_DELAY:  prdata = cce_pkg::APB_DW'(r_delay);
            cce_pkg::REG_REPEAT: prdata = cce_pkg::APB_DW'(r_repeat);
            default:             prdata = '0;
        endcase
    end

    // Clamped views used by the datapath
    always_comb begin
        if ($signed(r_gain) > cce_pkg::GAIN_MAX) begin
            o_gain = cce_pkg::GAIN_MAX;
        end else if ($signed(r_gain) < cce_pkg::GAIN_MIN) begin
            o_gain = cce_pkg::GAIN_MIN;
        end else begin
            o_gain = $signed(r_gain);
        end

        if (32'(r_delay) > 32'(MAX_DELAY - 1)) begin
            o_delay = PW'(MAX_DELAY - 1);
        end else begin
            o_delay = PW'(r_delay);
        end

        if (32'(r_repeat) > 32'(MAX_REPEAT)) begin
            o_reps = cce_pkg::REPEAT_W'(MAX_REPEAT);
        end else begin
            o_reps = r_repeat;
        end
    end

endmodule

`default_nettype wire

>>> sv/cce_front.sv
// Front end: accepts samples, tracks ring position and clip history,
// classifies the tap source and queues the transaction for the back end.
// Depends on cce_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cce_front #(
    parameter int MAX_DELAY    = cce_pkg::MAX_DELAY_DEF,
    parameter int SAMPLE_WIDTH = cce_pkg::SAMPLE_WIDTH_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  wire logic                           i_clip_start,
    input  wire logic [$clog2(MAX_DELAY)-1:0]   i_delay,
    output logic                                o_q_valid,
    input  wire logic                           i_q_ready,
    output logic signed [SAMPLE_WIDTH-1:0]      o_q_sample,
    output logic      [$clog2(MAX_DELAY)-1:0]   o_q_ptr,
    output cce_pkg::t_tap                       o_q_mode
);

    localparam int PW = $clog2(MAX_DELAY);
    localparam int CW = $clog2(MAX_DELAY + 1);

    logic [PW-1:0]                  r_wp;
    logic [CW-1:0]                  r_seen;
    logic [CW-1:0]                  seen_eff;
    cce_pkg::t_tap                  mode;

    logic signed [SAMPLE_WIDTH-1:0] r_q_sample [cce_pkg::Q_DEPTH];
    logic [PW-1:0]                  r_q_ptr    [cce_pkg::Q_DEPTH];
    cce_pkg::t_tap                  r_q_mode   [cce_pkg::Q_DEPTH];
    logic [cce_pkg::Q_AW-1:0]       r_wr;
    logic [cce_pkg::Q_AW-1:0]       r_rd;
    logic [cce_pkg::Q_AW:0]         r_cnt;
    logic                           push;
    logic                           pop;

    assign o_ready   = (r_cnt != (cce_pkg::Q_AW + 1)'(cce_pkg::Q_DEPTH));
    assign o_q_valid = (r_cnt != '0);
    assign push      = i_valid && o_ready;
    assign pop       = o_q_valid && i_q_ready;

    assign o_q_sample = r_q_sample[r_rd];
    assign o_q_ptr    = r_q_ptr[r_rd];
    assign o_q_mode   = r_q_mode[r_rd];

    // A new clip restarts the count before the tap check
    always_comb begin
        seen_eff = i_clip_start ? '0 : r_seen;
        if (i_delay == '0) begin
            mode = cce_pkg::TAP_SELF;
        end else if (seen_eff >= CW'(i_delay)) begin
            mode = cce_pkg::TAP_MEM;
        end else begin
            mode = cce_pkg::TAP_ZERO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_seen <= '0;
            r_wr   <= '0;
            r_rd   <= '0;
            r_cnt  <= '0;
        end else begin
            if (push) begin
                r_q_sample[r_wr] <= i_sample;
                r_q_ptr[r_wr]    <= r_wp;
                r_q_mode[r_wr]   <= mode;
                r_wr             <= r_wr + 1'b1;
                r_wp   <= (r_wp == PW'(MAX_DELAY - 1)) ? '0 : r_wp + 1'b1;
                r_seen <= (seen_eff < CW'(MAX_DELAY)) ? seen_eff + 1'b1 : seen_eff;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> sv/cce_back.sv
// Back end: runs the comb stages one after another on a shared multiplier,
// keeps the per-stage history rings in one RAM and holds the result register.
// Depends on cce_pkg and cce_ram.
`timescale 1ns / 1ps
`default_nettype none

module cce_back #(
    parameter int MAX_DELAY    = cce_pkg::MAX_DELAY_DEF,
    parameter int MAX_REPEAT   = cce_pkg::MAX_REPEAT_DEF,
    parameter int SAMPLE_WIDTH = cce_pkg::SAMPLE_WIDTH_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_q_valid,
    output logic                                     o_q_ready,
    input  wire logic signed [SAMPLE_WIDTH-1:0]      i_q_sample,
    input  wire logic [$clog2(MAX_DELAY)-1:0]        i_q_ptr,
    input  wire cce_pkg::t_tap                       i_q_mode,
    input  wire logic signed [cce_pkg::GAIN_W-1:0]   i_gain,
    input  wire logic [$clog2(MAX_DELAY)-1:0]        i_delay,
    input  wire logic [cce_pkg::REPEAT_W-1:0]        i_reps,
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic signed [SAMPLE_WIDTH-1:0]           o_sample,
    output logic                                     o_clipped
);

    localparam int PW    = $clog2(MAX_DELAY);
    localparam int STW   = SAMPLE_WIDTH + cce_pkg::STAGE_GUARD;
    localparam int PRW   = STW + cce_pkg::GAIN_W;
    localparam int SGW   = (MAX_REPEAT > 1) ? $clog2(MAX_REPEAT) : 1;
    localparam int DEPTH = MAX_REPEAT * MAX_DELAY;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [SGW-1:0] LAST = SGW'(MAX_REPEAT - 1);

    typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_ADD, ST_DONE} t_state;

    t_state                   r_state;
    logic [SGW-1:0]           r_stage;
    logic [PW-1:0]            r_ptr;
    cce_pkg::t_tap            r_mode;
    logic signed [STW-1:0]    r_x;
    logic signed [PRW-1:0]    r_prod;
    logic signed [STW-1:0]    r_result;
    logic                     r_clip;
    logic                     r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_out_sample;
    logic                     r_out_clip;

    logic signed [STW-1:0]    tap;
    logic signed [PRW-1:0]    n_prod;
    logic signed [PRW-1:0]    prod_rnd;
    logic signed [PRW-1:0]    prod_sh;
    logic signed [STW+1:0]    sum;
    logic signed [STW-1:0]    n_x;
    logic                     hit;
    logic                     stage_on;
    logic signed [SAMPLE_WIDTH-1:0] fin;
    logic                     fin_hit;
    logic                     out_free;

    logic [SGW-1:0]           rd_stage;
    logic [PW-1:0]            rd_ptr;
    logic [PW:0]              wrap_ptr;
    logic [PW-1:0]            tap_ptr;
    logic                     ram_re;
    logic                     ram_we;
    logic [AW-1:0]            ram_raddr;
    logic [AW-1:0]            ram_waddr;
    logic [STW-1:0]           ram_rdata;

    cce_ram #(
        .WIDTH (STW),
        .DEPTH (DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_x),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Tap read for the coming stage is issued in ST_IDLE or ST_ADD, the state before its multiply
    always_comb begin
        rd_stage = (r_state == ST_IDLE) ? '0 : r_stage + 1'b1;
        rd_ptr   = (r_state == ST_IDLE) ? i_q_ptr : r_ptr;
        wrap_ptr = {1'b0, rd_ptr} + (PW + 1)'(MAX_DELAY) - {1'b0, i_delay};
        tap_ptr  = (rd_ptr >= i_delay) ? rd_ptr - i_delay : wrap_ptr[PW-1:0];
        ram_raddr = AW'(rd_stage) * AW'(MAX_DELAY) + AW'(tap_ptr);
        ram_waddr = AW'(r_stage) * AW'(MAX_DELAY) + AW'(r_ptr);
        ram_re = ((r_state == ST_IDLE) && i_q_valid)
              || ((r_state == ST_ADD) && (r_stage != LAST));
        ram_we = (r_state == ST_MUL);
    end

    // Stage arithmetic
    always_comb begin
        case (r_mode)
            cce_pkg::TAP_SELF: tap = r_x;
            cce_pkg::TAP_MEM:  tap = $signed(ram_rdata);
            default:           tap = '0;
        endcase
        n_prod   = PRW'(tap * i_gain);
        prod_rnd = r_prod + $signed(PRW'(cce_pkg::ROUND_HALF));
        prod_sh  = prod_rnd >>> cce_pkg::FRAC_BITS;
        sum      = $signed({{2{r_x[STW-1]}}, r_x}) + $signed(prod_sh[STW+1:0]);
        hit      = !((&sum[STW+1:STW-1]) || !(|sum[STW+1:STW-1]));
        if (!hit) begin
            n_x = sum[STW-1:0];
        end else if (sum[STW+1]) begin
            n_x = $signed({1'b1, {(STW-1){1'b0}}});
        end else begin
            n_x = $signed({1'b0, {(STW-1){1'b1}}});
        end
        stage_on = (32'(r_stage) < 32'(i_reps));

        fin_hit = !((&r_result[STW-1:SAMPLE_WIDTH-1])
                 || !(|r_result[STW-1:SAMPLE_WIDTH-1]));
        if (!fin_hit) begin
            fin = r_result[SAMPLE_WIDTH-1:0];
        end else if (r_result[STW-1]) begin
            fin = $signed({1'b1, {(SAMPLE_WIDTH-1){1'b0}}});
        end else begin
            fin = $signed({1'b0, {(SAMPLE_WIDTH-1){1'b1}}});
        end
    end

    assign out_free  = !r_out_valid || i_ready;
    assign o_q_ready = (r_state == ST_IDLE);
    assign o_valid   = r_out_valid;
    assign o_sample  = r_out_sample;
    assign o_clipped = r_out_clip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_stage     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // In ST_DONE the result register is either held or reloaded below
            if (r_out_valid && i_ready && (r_state != ST_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_q_valid) begin
                        r_x      <= STW'(i_q_sample);
                        r_result <= STW'(i_q_sample);
                        r_ptr    <= i_q_ptr;
                        r_mode   <= i_q_mode;
                        r_stage  <= '0;
                        r_clip   <= 1'b0;
                        r_state  <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_prod  <= n_prod;
                    r_state <= ST_ADD;
                end
                ST_ADD: begin
                    r_x <= n_x;
                    if (stage_on) begin
                        r_result <= n_x;
                        r_clip   <= r_clip | hit;
                    end
                    if (r_stage == LAST) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_stage <= r_stage + 1'b1;
                        r_state <= ST_MUL;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_sample <= fin;
                        r_out_clip   <= r_clip | fin_hit;
                        r_state      <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire
